### hdl/largest_remainder_allocator_unit_macros.svh
// Assertion macros for the largest remainder allocator.
`ifndef LARGEST_REMAINDER_ALLOCATOR_UNIT_MACROS_SVH
`define LARGEST_REMAINDER_ALLOCATOR_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define LRA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LRA_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRA_ASSERT(label, clk, rstn, prop, msg)
`define LRA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### hdl/lra_pkg.sv
// Shared types and constants for the largest remainder allocator.
`timescale 1ns / 1ps
`default_nettype none
package lra_pkg;
    localparam logic [9:0] SCALE = 10'd1000;
    localparam logic [63:0] TMAX = 64'h7FFF_FFFF_FFFF_FFFF / 64'd1000;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOPAY = 2'd1;
    localparam logic [1:0] ST_NOELIG = 2'd2;
    localparam logic [1:0] ST_OVF = 2'd3;

    typedef struct packed {
        logic        start;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [62:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
        logic [62:0] remainder;
    } div_rsp_t;
endpackage
`default_nettype wire

### hdl/lra_divider.sv
// Restoring 128-by-63 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "largest_remainder_allocator_unit_macros.svh"
module lra_divider (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  lra_pkg::div_req_t   req,
    output lra_pkg::div_rsp_t   rsp
);
    import lra_pkg::*;

    logic [63:0] rem_reg, rem_next;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] quo_reg, quo_next;
    logic [62:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;

    always_comb begin
        rem_next = rem_reg;
        lo_next = lo_reg;
        quo_next = quo_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted = {rem_reg, lo_reg[63]};
        if (busy_reg) begin
            lo_next = {lo_reg[62:0], 1'b0};
            if (shifted >= {2'b00, d_reg}) begin
                rem_next = 64'(shifted - {2'b00, d_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            rem_next = req.hi;
            lo_next = req.lo;
            d_next = req.divisor;
            quo_next = '0;
            cnt_next = 7'd64;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        lo_reg <= lo_next;
        quo_reg <= quo_next;
        d_reg <= d_next;
        if (!aresetn) begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quotient = quo_reg;
    assign rsp.remainder = rem_reg[62:0];

    `LRA_ASSERT(a_done_after_busy, aclk, aresetn, rsp.done |-> $past(busy_reg), "done w/o busy")
    `LRA_ASSERT(a_busy_count, aclk, aresetn, busy_reg |-> cnt_reg != 7'd0, "busy count zero")
    `LRA_ASSERT(a_start_idle, aclk, aresetn, (req.start && !busy_reg) |=> busy_reg, "no start")
endmodule
`default_nettype wire

### hdl/largest_remainder_allocator_unit.sv
// Top level of the largest remainder allocator: loader, sequencer, ranking, output.
// Load: one item per cycle while in S_LOAD (a memory write and a running-sum check).
// On the marked item: the stores are cleared, then, only for a set with status OK, per eligible
// entry a 64x64 multiply (32x32 partial products on one shared multiplier) and a 64-step divide,
// then remainder ranking on one shared comparator; then one result at a time, each held until
// taken (S_OUT, then S_OUTW). The input is not ready until the last result is taken.
// aresetn synchronous active low clears the sequencer and per-set state.
`timescale 1ns / 1ps
`default_nettype none
`include "largest_remainder_allocator_unit_macros.svh"
module largest_remainder_allocator_unit #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [127:0] s_tdata,   // transfer_amount[63:0], savings[127:64]
    input  wire          s_tlast,   // last_item
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [135:0] m_tdata,   // entry_index[5:0], payout[68:6], share_remainder[131:69], status[133:132], zero fill
    output logic         m_tlast    // last_result
);
    import lra_pkg::*;

    localparam int AW = 6;

    typedef enum logic [9:0] {
        S_LOAD  = 10'b0000000001,
        S_CLR   = 10'b0000000010,
        S_RD    = 10'b0000000100,
        S_MUL   = 10'b0000001000,
        S_DIV   = 10'b0000010000,
        S_WAIT  = 10'b0000100000,
        S_RANKI = 10'b0001000000,
        S_RANKJ = 10'b0010000000,
        S_OUT   = 10'b0100000000,
        S_OUTW  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [63:0] sav_mem [64];
    logic [62:0] pay_mem [64];
    logic [62:0] rem_mem [64];
    logic        elig_mem [64];

    logic [62:0] sum_reg, sum_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [62:0] total_reg, total_next;
    logic        ovf_reg, ovf_next;
    logic        nopay_reg, nopay_next;
    logic [1:0]  stat_reg, stat_next;
    logic [62:0] left_reg, left_next;
    logic [6:0]  i_reg, i_next;
    logic [6:0]  j_reg, j_next;
    logic [6:0]  rank_reg, rank_next;
    logic [1:0]  ph_reg, ph_next;
    logic [127:0] prod_reg, prod_next;
    logic [63:0] sav_rd_reg;
    logic [62:0] rem_i_reg, rem_j_reg, pay_rd_reg;
    logic        elig_j_reg, elig_i_reg;
    logic [63:0] mul_res;
    logic [31:0] ma, mb;
    logic [63:0] t_in, s_in;
    logic        accept, sav_pos;
    logic [63:0] sum_ext;
    logic [5:0]  rd_addr;
    div_req_t    dreq;
    div_rsp_t    drsp;
    logic        pay_we, rem_we;
    logic [5:0]  wr_addr;
    logic [62:0] pay_wd, rem_wd;

    assign t_in = s_tdata[63:0];
    assign s_in = s_tdata[127:64];
    assign s_tready = (state_reg == S_LOAD);
    assign accept = s_tvalid && s_tready;
    assign sav_pos = (s_in != 64'd0) && !s_in[63];
    assign sum_ext = {1'b0, sum_reg} + s_in;

    always_comb begin
        case (ph_reg)
            2'd0: begin ma = total_reg[31:0]; mb = sav_rd_reg[31:0]; end
            2'd1: begin ma = total_reg[31:0]; mb = sav_rd_reg[63:32]; end
            2'd2: begin ma = {1'b0, total_reg[62:32]}; mb = sav_rd_reg[31:0]; end
            default: begin ma = {1'b0, total_reg[62:32]}; mb = sav_rd_reg[63:32]; end
        endcase
        mul_res = ma * mb;
    end

    lra_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    always_comb begin
        state_next = state_reg;
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        total_next = total_reg;
        ovf_next = ovf_reg;
        nopay_next = nopay_reg;
        stat_next = stat_reg;
        left_next = left_reg;
        i_next = i_reg;
        j_next = j_reg;
        rank_next = rank_reg;
        ph_next = ph_reg;
        prod_next = prod_reg;
        dreq.start = 1'b0;
        dreq.hi = prod_reg[127:64];
        dreq.lo = prod_reg[63:0];
        dreq.divisor = sum_reg;
        pay_we = 1'b0;
        rem_we = 1'b0;
        wr_addr = i_reg[AW-1:0];
        pay_wd = '0;
        rem_wd = '0;
        rd_addr = i_reg[AW-1:0];
        m_tvalid = 1'b0;
        case (state_reg)
            S_LOAD: begin
                if (accept) begin
                    logic np;
                    logic ov;
                    np = nopay_reg;
                    ov = ovf_reg;
                    if (cnt_reg == 7'd0) begin
                        np = (t_in == 64'd0) || t_in[63];
                        total_next = '0;
                        if (!np) begin
                            if (t_in > TMAX) ov = 1'b1;
                            else total_next = 63'(t_in * 64'(SCALE));
                        end
                    end
                    if (cnt_reg < 7'(MAX_ENTRIES)) begin
                        cnt_next = cnt_reg + 7'd1;
                        if (sav_pos) begin
                            if (sum_ext[63]) ov = 1'b1;
                            else sum_next = sum_ext[62:0];
                        end
                    end else begin
                        ov = 1'b1;
                    end
                    nopay_next = np;
                    ovf_next = ov;
                    if (s_tlast) begin
                        if (np) stat_next = ST_NOPAY;
                        else if (ov) stat_next = ST_OVF;
                        else if (sum_next == 63'd0) stat_next = ST_NOELIG;
                        else stat_next = ST_OK;
                        left_next = total_next;
                        i_next = '0;
                        state_next = S_CLR;
                    end
                end
            end
            S_CLR: begin
                pay_we = 1'b1;
                rem_we = 1'b1;
                if (i_reg + 7'd1 >= cnt_reg) begin
                    i_next = '0;
                    state_next = (stat_reg == ST_OK) ? S_RD : S_OUT;
                end else i_next = i_reg + 7'd1;
            end
            S_RD: begin
                ph_next = 2'd0;
                prod_next = '0;
                state_next = S_MUL;
            end
            S_MUL: begin
                if (!(sav_rd_reg != 64'd0 && !sav_rd_reg[63])) begin
                    if (i_reg + 7'd1 >= cnt_reg) begin
                        i_next = '0; j_next = '0; rank_next = '0;
                        state_next = S_RANKI;
                    end else begin
                        i_next = i_reg + 7'd1;
                        state_next = S_RD;
                    end
                end else begin
                    case (ph_reg)
                        2'd0: prod_next = prod_reg + {64'd0, mul_res};
                        2'd1, 2'd2: prod_next = prod_reg + {32'd0, mul_res, 32'd0};
                        default: prod_next = prod_reg + {mul_res, 64'd0};
                    endcase
                    ph_next = ph_reg + 2'd1;
                    if (ph_reg == 2'd3) state_next = S_DIV;
                end
            end
            S_DIV: begin
                dreq.start = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (drsp.done) begin
                    pay_we = 1'b1;
                    rem_we = 1'b1;
                    pay_wd = drsp.quotient[62:0];
                    rem_wd = drsp.remainder;
                    left_next = left_reg - drsp.quotient[62:0];
                    if (i_reg + 7'd1 >= cnt_reg) begin
                        i_next = '0; j_next = '0; rank_next = '0;
                        state_next = S_RANKI;
                    end else begin
                        i_next = i_reg + 7'd1;
                        state_next = S_RD;
                    end
                end
            end
            S_RANKI: begin
                rd_addr = j_reg[AW-1:0];
                state_next = S_RANKJ;
            end
            S_RANKJ: begin
                rd_addr = 6'(j_reg + 7'd1);
                if (elig_j_reg && j_reg != i_reg && (rem_j_reg > rem_i_reg ||
                    (rem_j_reg == rem_i_reg && j_reg < i_reg)))
                    rank_next = rank_reg + 7'd1;
                if (j_reg + 7'd1 >= cnt_reg) begin
                    if (elig_i_reg &&
                        {56'd0, rank_next} < left_reg) begin
                        pay_we = 1'b1;
                        pay_wd = pay_rd_reg + 63'd1;
                    end
                    j_next = '0;
                    rank_next = '0;
                    if (i_reg + 7'd1 >= cnt_reg) begin
                        i_next = '0;
                        state_next = S_OUT;
                    end else begin
                        i_next = i_reg + 7'd1;
                        state_next = S_RANKI;
                    end
                end else j_next = j_reg + 7'd1;
            end
            S_OUT: begin
                state_next = S_OUTW;
            end
            S_OUTW: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (i_reg + 7'd1 >= cnt_reg) begin
                        sum_next = '0; cnt_next = '0; total_next = '0;
                        ovf_next = 1'b0; nopay_next = 1'b0;
                        state_next = S_LOAD;
                    end else begin
                        i_next = i_reg + 7'd1;
                        state_next = S_OUT;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept && cnt_reg < 7'(MAX_ENTRIES)) begin
            sav_mem[cnt_reg[AW-1:0]] <= s_in;
            elig_mem[cnt_reg[AW-1:0]] <= sav_pos;
        end
        if (pay_we) pay_mem[wr_addr] <= pay_wd;
        if (rem_we) rem_mem[wr_addr] <= rem_wd;
        sav_rd_reg <= sav_mem[i_reg[AW-1:0]];
        rem_i_reg <= rem_mem[i_reg[AW-1:0]];
        pay_rd_reg <= pay_mem[i_reg[AW-1:0]];
        elig_i_reg <= elig_mem[i_reg[AW-1:0]];
        rem_j_reg <= rem_mem[rd_addr];
        elig_j_reg <= elig_mem[rd_addr];
        prod_reg <= prod_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            sum_reg <= '0; cnt_reg <= '0; total_reg <= '0;
            ovf_reg <= 1'b0; nopay_reg <= 1'b0; stat_reg <= ST_OK;
            left_reg <= '0; i_reg <= '0; j_reg <= '0; rank_reg <= '0; ph_reg <= '0;
        end else begin
            state_reg <= state_next;
            sum_reg <= sum_next; cnt_reg <= cnt_next; total_reg <= total_next;
            ovf_reg <= ovf_next; nopay_reg <= nopay_next; stat_reg <= stat_next;
            left_reg <= left_next; i_reg <= i_next; j_reg <= j_next;
            rank_reg <= rank_next; ph_reg <= ph_next;
        end
    end

    assign m_tdata = {2'b00, stat_reg, rem_i_reg, pay_rd_reg, i_reg[AW-1:0]};
    assign m_tlast = (i_reg + 7'd1 >= cnt_reg);

    `LRA_ASSERT(a_ready_only_load, aclk, aresetn, s_tready |-> !m_tvalid, "ready while out")
    `LRA_ASSERT(a_cnt_limit, aclk, aresetn, cnt_reg <= 7'(MAX_ENTRIES), "count over max")
    `LRA_ASSERT(a_out_index, aclk, aresetn, m_tvalid |-> i_reg < cnt_reg, "index beyond set")
    `LRA_ASSERT(a_last_clear, aclk, aresetn, (m_tvalid && m_tready && m_tlast) |=> cnt_reg == 7'd0, "set not cleared")
endmodule
`default_nettype wire

### verif/largest_remainder_allocator_unit_test.sv
// Self-checking testbench for the largest remainder allocator: directed and random sets.
`timescale 1ns / 1ps
module largest_remainder_allocator_unit_test;
    import lra_pkg::*;

    localparam int NMAX = 64;
    localparam logic [63:0] I64MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int LIMIT = 3_000_000;

    typedef struct packed {
        logic [5:0]  idx;
        logic [62:0] payout;
        logic [62:0] rem;
        logic [1:0]  status;
        logic        last;
    } share_t;

    typedef struct {
        logic [63:0] amount;
        logic [63:0] savings;
        logic        last;
        logic        has_exp;
        logic [1:0]  exp_status;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         m_tlast;

    largest_remainder_allocator_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // allocator state mirror
    logic [63:0] set_savings [NMAX];
    logic [63:0] set_sum;
    int          set_count;
    logic [63:0] set_total;
    logic        set_ovf;
    logic        set_nopay;

    share_t expected_shares[$];
    logic [2:0] typed_status[$];
    int     errors = 0;
    int     cycles = 0;
    int     send_idle = 33;
    int     recv_idle = 88;

    task automatic report(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic logic positive(input logic [63:0] v);
        return v != 0 && !v[63];
    endfunction

    task automatic allocate(input logic [63:0] amount, input logic [63:0] sv, input logic last,
                            input logic chk, input logic [1:0] chk_st);
        logic [127:0] prod;
        logic [63:0] pay [NMAX];
        logic [63:0] rm [NMAX];
        logic [63:0] given;
        logic [63:0] rank;
        logic [1:0] st;
        share_t r;
        if (set_count == 0) begin
            set_nopay = amount == 0 || amount[63];
            set_total = 0;
            if (!set_nopay) begin
                if (amount > TMAX) set_ovf = 1'b1;
                else set_total = amount * 64'd1000;
            end
        end
        if (set_count < NMAX) begin
            set_savings[set_count] = sv;
            set_count++;
            if (positive(sv)) begin
                if (set_sum > I64MAX - sv) set_ovf = 1'b1;
                else set_sum += sv;
            end
        end else begin
            set_ovf = 1'b1;
        end
        if (!last) return;
        st = set_nopay ? ST_NOPAY : set_ovf ? ST_OVF : set_sum == 0 ? ST_NOELIG : ST_OK;
        given = 0;
        for (int i = 0; i < set_count; i++) begin
            pay[i] = 0;
            rm[i] = 0;
            if (st == ST_OK && positive(set_savings[i])) begin
                prod = set_total * set_savings[i];
                pay[i] = prod / set_sum;
                rm[i] = prod % set_sum;
                given += pay[i];
            end
        end
        if (st == ST_OK)
            for (int i = 0; i < set_count; i++) begin
                rank = 0;
                if (!positive(set_savings[i])) continue;
                for (int j = 0; j < set_count; j++)
                    if (j != i && positive(set_savings[j]) &&
                        (rm[j] > rm[i] || (rm[j] == rm[i] && j < i)))
                        rank++;
                if (rank < set_total - given) pay[i] += 1;
            end
        for (int i = 0; i < set_count; i++) begin
            r.idx = i[5:0];
            r.payout = pay[i][62:0];
            r.rem = rm[i][62:0];
            r.status = st;
            r.last = (i + 1 == set_count);
            expected_shares.push_back(r);
            typed_status.push_back({chk, chk_st});
        end
        set_sum = 0;
        set_count = 0;
        set_total = 0;
        set_ovf = 1'b0;
        set_nopay = 1'b0;
    endtask

    task automatic send(input logic [63:0] amount, input logic [63:0] sv, input logic last,
                        input logic chk, input logic [1:0] chk_st);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {sv, amount};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        allocate(amount, sv, last, chk, chk_st);
        @(negedge aclk);
    endtask

    task automatic send_set(input int n, input logic [63:0] amount, input int mode);
        logic [63:0] sv;
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: sv = {32'd0, $urandom};
                1: sv = {$urandom, $urandom};
                2: sv = {1'b0, $urandom} >> $urandom_range(60, 0);
                default: sv = $urandom_range(20, 0) - 4;
            endcase
            send(i == 0 ? amount : {$urandom, $urandom}, sv, i == n - 1, 1'b0, ST_OK);
        end
    endtask

    always @(posedge aclk) begin
        share_t got, exp;
        logic [2:0] tchk;
        cycles++;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[5:0], m_tdata[68:6], m_tdata[131:69], m_tdata[133:132], m_tlast};
            if (expected_shares.size() == 0) begin
                report("unexpected result transfer");
            end else begin
                exp = expected_shares.pop_front();
                tchk = typed_status.pop_front();
                if (tchk[2] && got.status != tchk[1:0]) report("status (directed)");
                if (got.idx != exp.idx) report("entry_index");
                if (got.payout != exp.payout) report($sformatf("payout %0d exp %0d",
                                                               got.payout, exp.payout));
                if (got.rem != exp.rem) report("share_remainder");
                if (got.status != exp.status) report("status");
                if (got.last != exp.last) report("last_result");
            end
        end
    end

    always @(negedge aclk)
        m_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);

    row_t rows[$];

    task automatic add_row(input logic [63:0] a, input logic [63:0] s, input logic l,
                           input logic h, input logic [1:0] st);
        row_t r;
        r.amount = a; r.savings = s; r.last = l; r.has_exp = h; r.exp_status = st;
        rows.push_back(r);
    endtask

    initial begin
        int k;
        set_sum = 0; set_count = 0; set_total = 0; set_ovf = 0; set_nopay = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        add_row(64'd0, 64'd5, 1, 1, ST_NOPAY);
        add_row(64'h8000_0000_0000_0000, I64MAX, 1, 1, ST_NOPAY);
        add_row(TMAX + 1, 64'd7, 1, 1, ST_OVF);
        add_row(TMAX, I64MAX, 1, 0, ST_OK);
        add_row(64'd5, 64'd0, 0, 1, ST_NOELIG);
        add_row(64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, ST_NOELIG);
        add_row(64'd3, I64MAX, 0, 1, ST_OVF);
        add_row(64'd9, 64'd1, 1, 1, ST_OVF);
        add_row(64'd1, 64'd1, 0, 0, ST_OK);
        add_row(64'd2, 64'd1, 0, 0, ST_OK);
        add_row(64'd3, 64'd1, 1, 0, ST_OK);
        add_row(64'd7, 64'd3, 0, 0, ST_OK);
        add_row(64'd7, 64'h8000_0000_0000_0000, 0, 0, ST_OK);
        add_row(64'd7, 64'd6, 1, 0, ST_OK);
        add_row(I64MAX, I64MAX, 1, 1, ST_OVF);
        add_row(-64'sd1, 64'd4, 1, 1, ST_NOPAY);
        foreach (rows[i])
            send(rows[i].amount, rows[i].savings, rows[i].last, rows[i].has_exp,
                 rows[i].exp_status);
        // set longer than the store
        for (int i = 0; i < NMAX + 2; i++)
            send(i == 0 ? 64'd1000 : 64'd0, $urandom_range(9, 1), i == NMAX + 1, 1'b0, ST_OK);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = phase == 0 ? 33 : phase == 1 ? 88 : 0;
            recv_idle = phase == 0 ? 88 : phase == 1 ? 33 : 0;
            k = 0;
            while (k < 45) begin
                int n, mode;
                logic [63:0] amt;
                n = $urandom_range(9) == 0 ? $urandom_range(64, 10) : $urandom_range(6, 1);
                mode = $urandom_range(3);
                case ($urandom_range(9))
                    0: amt = {$urandom, $urandom};
                    1: amt = TMAX - $urandom_range(3);
                    2: amt = TMAX + $urandom_range(3, 1);
                    default: amt = $urandom_range(1_000_000, 1);
                endcase
                send_set(n, amt, mode);
                k += n;
            end
            s_tvalid <= 1'b0;
            while (expected_shares.size() > 0) @(posedge aclk);
            @(negedge aclk);
        end
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_shares.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
